// ===== sv/spllp_pkg.sv =====
// Shared constants, record types and link helpers for the sorted per-site list pool.
package spllp_pkg;

	localparam int NUM_SITES = 64;
	localparam int POOL_SIZE = 1024;
	localparam int KEY_BITS  = 32;

	localparam int SITE_W   = $clog2(NUM_SITES);
	localparam int IDX_W    = $clog2(POOL_SIZE);
	localparam int LINK_W   = IDX_W + 1;
	localparam int TYPE_W   = 2;
	localparam int KEY_IN_W = 32;
	localparam int STEP_W   = $clog2(POOL_SIZE + 1);

	// Input tdata layout, lowest field first.
	localparam int IN_SITE_LO  = 0;
	localparam int IN_IDX_LO   = IN_SITE_LO + SITE_W;
	localparam int IN_NEW_LO   = IN_IDX_LO + IDX_W;
	localparam int IN_KEY_LO   = IN_NEW_LO + IDX_W;
	localparam int IN_BITS     = IN_KEY_LO + KEY_IN_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

	// Output tdata layout, lowest field first.
	localparam int OUT_SITE_LO = 0;
	localparam int OUT_L_LO    = OUT_SITE_LO + SITE_W;
	localparam int OUT_R_LO    = OUT_L_LO + LINK_W;
	localparam int OUT_BITS    = OUT_R_LO + LINK_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [TYPE_W-1:0] OP_INSERT  = TYPE_W'(0);
	localparam logic [TYPE_W-1:0] OP_REMOVE  = TYPE_W'(1);
	localparam logic [TYPE_W-1:0] OP_RELABEL = TYPE_W'(2);

	typedef logic [LINK_W-1:0] link_t;
	localparam link_t LINK_NONE = '1;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [SITE_W-1:0]   site;
		link_t               prev;
		link_t               next;
	} rec_t;

	// One pending neighbor repair: write val into a link field of entry addr.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		link_t            val;
	} fix_t;

	function automatic logic is_slot(link_t v);
		return v < LINK_W'(POOL_SIZE);
	endfunction

	function automatic link_t to_link(logic [IDX_W-1:0] i);
		return {1'b0, i};
	endfunction

	function automatic link_t norm_link(link_t v);
		return is_slot(v) ? v : LINK_NONE;
	endfunction

endpackage

// ===== sv/sorted_per_site_linked_list_pool.sv =====
// Sorted per-site doubly linked list pool: sequencer over a list head memory and an entry memory.
// Insert walks the site's list one entry per read, then links the entry and repairs both neighbors;
// remove repairs both neighbors and clears the entry's links; relabel walks the site's list.
// One item is in flight at a time; the next item is taken after the result has been delivered.
// The entry memory has one write and one read port and sets the rate through the list walks.
// Reset empties every list at once through per-site valid flops; entry memory is not cleared.
module sorted_per_site_linked_list_pool
	import spllp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// site, entry_index, new_index, time_key (lowest bits first), zero padded
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic [TYPE_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// entry_site, left_neighbor, right_neighbor (lowest bits first), zero padded
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// done_type
	output logic [TYPE_W-1:0]      m_tuser
);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b000000000001,
		ST_INS_HEAD = 12'b000000000010,
		ST_INS_WALK = 12'b000000000100,
		ST_INS_LINK = 12'b000000001000,
		ST_FIXA     = 12'b000000010000,
		ST_FIXB     = 12'b000000100000,
		ST_REM_REC  = 12'b000001000000,
		ST_REM_CLR  = 12'b000010000000,
		ST_REL_REC  = 12'b000100000000,
		ST_REL_WALK = 12'b001000000000,
		ST_REL_FIN  = 12'b010000000000,
		ST_DONE     = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_vld_q;
	logic   in_acc;

	logic [SITE_W-1:0]   in_site;
	logic [IDX_W-1:0]    in_idx;
	logic [IDX_W-1:0]    in_new;
	logic [KEY_BITS-1:0] in_key;

	logic [TYPE_W-1:0]   type_q;
	logic [SITE_W-1:0]   site_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    new_q;
	logic [KEY_BITS-1:0] key_q;

	link_t             cur_q, cur_d;
	link_t             before_q, before_d;
	logic [STEP_W-1:0] steps_q, steps_d, steps_n;
	fix_t              fix_a_q, fix_a_d, fix_b_q, fix_b_d;
	rec_t              hold_q, hold_d;
	logic [SITE_W-1:0] res_site_q, res_site_d;
	link_t             res_l_q, res_l_d, res_r_q, res_r_d;

	// Entry memory: one write port, one read port, registered read with write forwarding.
	rec_t             rec_mem [POOL_SIZE];
	rec_t             rec_rd_q;
	logic             rec_we;
	logic [IDX_W-1:0] rec_waddr, rec_raddr;
	rec_t             rec_wdata;

	// List head memory; a head whose valid flop is clear reads as an empty list.
	link_t             head_mem [NUM_SITES];
	link_t             head_rd_q;
	logic              head_hit_q;
	logic [NUM_SITES-1:0] head_vld_q;
	logic              head_we;
	logic [SITE_W-1:0] head_waddr, head_raddr;
	link_t             head_wdata;
	link_t             head_eff;

	link_t from_l, to_l, cur_norm, walk_nn, walk_np;

	assign in_site = s_tdata[IN_SITE_LO +: SITE_W];
	assign in_idx  = s_tdata[IN_IDX_LO +: IDX_W];
	assign in_new  = s_tdata[IN_NEW_LO +: IDX_W];
	assign in_key  = KEY_BITS'(s_tdata[IN_KEY_LO +: KEY_IN_W]);

	assign s_tready = (state_q == ST_IDLE) && !out_vld_q;
	assign in_acc   = s_tvalid && s_tready;

	assign head_raddr = in_site;
	assign head_eff   = head_hit_q ? head_rd_q : LINK_NONE;
	assign from_l     = to_link(idx_q);
	assign to_l       = to_link(new_q);
	assign cur_norm   = norm_link(cur_q);
	assign steps_n    = steps_q + STEP_W'(1);
	assign walk_nn    = (rec_rd_q.next == from_l) ? to_l : rec_rd_q.next;
	assign walk_np    = (rec_rd_q.prev == from_l) ? to_l : rec_rd_q.prev;

	always_comb begin
		state_d    = state_q;
		rec_we     = 1'b0;
		rec_waddr  = idx_q;
		rec_wdata  = rec_rd_q;
		rec_raddr  = idx_q;
		head_we    = 1'b0;
		head_waddr = site_q;
		head_wdata = LINK_NONE;
		cur_d      = cur_q;
		before_d   = before_q;
		steps_d    = steps_q;
		fix_a_d    = fix_a_q;
		fix_b_d    = fix_b_q;
		hold_d     = hold_q;
		res_site_d = res_site_q;
		res_l_d    = res_l_q;
		res_r_d    = res_r_q;
		unique case (state_q)
			ST_IDLE: begin
				rec_raddr = in_idx;
				if (in_acc) begin
					res_site_d = in_site;
					res_l_d    = LINK_NONE;
					res_r_d    = LINK_NONE;
					case (s_tuser)
						OP_INSERT:  state_d = ST_INS_HEAD;
						OP_REMOVE:  state_d = ST_REM_REC;
						OP_RELABEL: state_d = ST_REL_REC;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_HEAD: begin
				cur_d    = head_eff;
				before_d = LINK_NONE;
				steps_d  = '0;
				rec_raddr = head_eff[IDX_W-1:0];
				state_d  = is_slot(head_eff) ? ST_INS_WALK : ST_INS_LINK;
			end
			ST_INS_WALK: begin
				if (rec_rd_q.key < key_q) begin
					before_d  = cur_q;
					cur_d     = rec_rd_q.next;
					steps_d   = steps_n;
					rec_raddr = rec_rd_q.next[IDX_W-1:0];
					if (!(is_slot(rec_rd_q.next) && (steps_n < STEP_W'(POOL_SIZE)))) begin
						state_d = ST_INS_LINK;
					end
				end else begin
					state_d = ST_INS_LINK;
				end
			end
			ST_INS_LINK: begin
				rec_we     = 1'b1;
				rec_waddr  = idx_q;
				rec_wdata  = '{key: key_q, site: site_q, prev: before_q, next: cur_norm};
				head_we    = !is_slot(before_q);
				head_waddr = site_q;
				head_wdata = to_link(idx_q);
				fix_a_d    = '{en: is_slot(before_q), addr: before_q[IDX_W-1:0],
					val: to_link(idx_q)};
				fix_b_d    = '{en: is_slot(cur_norm), addr: cur_norm[IDX_W-1:0],
					val: to_link(idx_q)};
				res_l_d    = before_q;
				res_r_d    = cur_norm;
				rec_raddr  = before_q[IDX_W-1:0];
				state_d    = ST_FIXA;
			end
			ST_FIXA: begin
				// Predecessor's next link.
				rec_we    = fix_a_q.en;
				rec_waddr = fix_a_q.addr;
				rec_wdata = '{key: rec_rd_q.key, site: rec_rd_q.site, prev: rec_rd_q.prev,
					next: fix_a_q.val};
				rec_raddr = fix_b_q.addr;
				state_d   = ST_FIXB;
			end
			ST_FIXB: begin
				// Successor's prev link.
				rec_we    = fix_b_q.en;
				rec_waddr = fix_b_q.addr;
				rec_wdata = '{key: rec_rd_q.key, site: rec_rd_q.site, prev: fix_b_q.val,
					next: rec_rd_q.next};
				state_d   = (type_q == OP_REMOVE) ? ST_REM_CLR : ST_DONE;
			end
			ST_REM_REC: begin
				hold_d     = rec_rd_q;
				res_site_d = rec_rd_q.site;
				res_l_d    = rec_rd_q.prev;
				res_r_d    = rec_rd_q.next;
				head_we    = !is_slot(rec_rd_q.prev);
				head_waddr = rec_rd_q.site;
				head_wdata = rec_rd_q.next;
				fix_a_d    = '{en: is_slot(rec_rd_q.prev), addr: rec_rd_q.prev[IDX_W-1:0],
					val: rec_rd_q.next};
				fix_b_d    = '{en: is_slot(rec_rd_q.next), addr: rec_rd_q.next[IDX_W-1:0],
					val: rec_rd_q.prev};
				rec_raddr  = rec_rd_q.prev[IDX_W-1:0];
				state_d    = ST_FIXA;
			end
			ST_REM_CLR: begin
				rec_we    = 1'b1;
				rec_waddr = idx_q;
				rec_wdata = '{key: hold_q.key, site: hold_q.site, prev: LINK_NONE,
					next: LINK_NONE};
				state_d   = ST_DONE;
			end
			ST_REL_REC: begin
				// Copy the old record, then start the link walk from the possibly moved head.
				rec_we    = 1'b1;
				rec_waddr = new_q;
				rec_wdata = rec_rd_q;
				steps_d   = '0;
				if (head_eff == from_l) begin
					head_we    = 1'b1;
					head_waddr = site_q;
					head_wdata = to_l;
					cur_d      = to_l;
				end else begin
					cur_d = head_eff;
				end
				if (is_slot(cur_d)) begin
					rec_raddr = cur_d[IDX_W-1:0];
					state_d   = ST_REL_WALK;
				end else begin
					rec_raddr = new_q;
					state_d   = ST_REL_FIN;
				end
			end
			ST_REL_WALK: begin
				rec_we    = (walk_nn != rec_rd_q.next) || (walk_np != rec_rd_q.prev);
				rec_waddr = cur_q[IDX_W-1:0];
				rec_wdata = '{key: rec_rd_q.key, site: rec_rd_q.site, prev: walk_np,
					next: walk_nn};
				cur_d     = walk_nn;
				steps_d   = steps_n;
				if (is_slot(walk_nn) && (steps_n < STEP_W'(POOL_SIZE))) begin
					rec_raddr = walk_nn[IDX_W-1:0];
				end else begin
					rec_raddr = new_q;
					state_d   = ST_REL_FIN;
				end
			end
			ST_REL_FIN: begin
				res_l_d = rec_rd_q.prev;
				res_r_d = rec_rd_q.next;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			type_q <= s_tuser;
			site_q <= in_site;
			idx_q  <= in_idx;
			new_q  <= in_new;
			key_q  <= in_key;
		end
		cur_q      <= cur_d;
		before_q   <= before_d;
		steps_q    <= steps_d;
		fix_a_q    <= fix_a_d;
		fix_b_q    <= fix_b_d;
		hold_q     <= hold_d;
		res_site_q <= res_site_d;
		res_l_q    <= res_l_d;
		res_r_q    <= res_r_d;
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		rec_rd_q <= (rec_we && (rec_waddr == rec_raddr)) ? rec_wdata : rec_mem[rec_raddr];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rd_q  <= head_mem[head_raddr];
		head_hit_q <= head_vld_q[head_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
		end else if (head_we) begin
			head_vld_q[head_waddr] <= 1'b1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = type_q;
	assign m_tdata  = OUT_TDATA_W'({norm_link(res_r_q), norm_link(res_l_q), res_site_q});

	a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != ST_IDLE))
		else $error("accepted item did not start an operation");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the completion state");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_INS_WALK) || (state_q == ST_REL_WALK)) |->
			(steps_q < STEP_W'(POOL_SIZE)))
		else $error("list walk ran past the pool size");

	a_head_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		head_we |-> ((state_q != ST_IDLE) && !out_vld_q))
		else $error("list head written while no operation was active");

endmodule
